### hdl/mtts_pkg.sv
`default_nettype none

package mtts_pkg;

    localparam logic [23:0] DEFAULT_TEMPO_RESET = 24'd500000;

    localparam logic [7:0] ST_META     = 8'hFF;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] ST_SYSEX    = 8'hF0;
    localparam logic [7:0] ST_SYSEX_CT = 8'hF7;
    localparam logic [7:0] ST_SYSTEM   = 8'hF0;
    localparam logic [7:0] ST_CHANNEL  = 8'h80;

    localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
    localparam logic [3:0] HI_NOTE_ON   = 4'h9;
    localparam logic [3:0] HI_POLY_AT   = 4'hA;
    localparam logic [3:0] HI_CTRL      = 4'hB;
    localparam logic [3:0] HI_PITCH     = 4'hE;
    localparam logic [3:0] HI_PROGRAM   = 4'hC;
    localparam logic [3:0] HI_CHAN_AT   = 4'hD;

    localparam logic [2:0] HDR_LEN_START = 3'd4;
    localparam logic [2:0] HDR_LAST      = 3'd7;
    localparam logic [31:0] TEMPO_LEN    = 32'd3;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_HEADER    = 4'd1,
        PH_DELTA     = 4'd2,
        PH_STATUS    = 4'd3,
        PH_META_TYPE = 4'd4,
        PH_META_LEN  = 4'd5,
        PH_SYSEX_LEN = 4'd6,
        PH_SKIP      = 4'd7,
        PH_TEMPO     = 4'd8,
        PH_DONE      = 4'd9
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_start;
    } req_item_t;

    typedef struct packed {
        logic [23:0] tempo_period;
        logic        tempo_found;
    } rsp_item_t;

    function automatic logic [1:0] data_bytes_for(input logic [7:0] status);
        logic [3:0] hi;
        hi = status[7:4];
        if (hi == HI_NOTE_OFF || hi == HI_NOTE_ON || hi == HI_POLY_AT ||
            hi == HI_CTRL || hi == HI_PITCH)
            return 2'd2;
        if (hi == HI_PROGRAM || hi == HI_CHAN_AT)
            return 2'd1;
        return 2'd0;
    endfunction

endpackage

`default_nettype wire

### hdl/mtts_core.sv
`default_nettype none

module mtts_core
    import mtts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire req_item_t   item,
    input  wire logic [23:0] default_tempo,
    output logic             emit,
    output rsp_item_t        result
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  header_count_reg, header_count_next;
    logic [31:0] chunk_length_reg, chunk_length_next;
    logic [31:0] bytes_consumed_reg, bytes_consumed_next;
    logic [31:0] vlq_value_reg, vlq_value_next;
    logic [31:0] skip_remaining_reg, skip_remaining_next;
    logic [7:0]  meta_kind_reg, meta_kind_next;
    logic [23:0] tempo_accum_reg, tempo_accum_next;
    logic [7:0]  running_status_reg, running_status_next;

    phase_t      ph;
    logic [2:0]  hc;
    logic [31:0] cl;
    logic [31:0] bc;
    logic [31:0] vlq;
    logic [31:0] skip;
    logic [7:0]  meta;
    logic [23:0] tacc;
    logic [7:0]  rs;

    logic [7:0]  b;
    logic [31:0] bc_inc;
    logic [31:0] vlq_shift;
    logic [31:0] len_shift;
    logic [31:0] skip_dec;
    logic [1:0]  n_status;
    logic [1:0]  n_run;
    logic        end_hit;
    logic        is_tempo;

    // restart clears the scan before the byte is taken
    always_comb
    begin
        b = item.data_byte;
        if (item.chunk_start)
        begin
            ph   = PH_HEADER;
            hc   = '0;
            cl   = '0;
            bc   = '0;
            vlq  = '0;
            skip = '0;
            meta = '0;
            tacc = '0;
            rs   = '0;
        end
        else
        begin
            ph   = phase_reg;
            hc   = header_count_reg;
            cl   = chunk_length_reg;
            bc   = bytes_consumed_reg;
            vlq  = vlq_value_reg;
            skip = skip_remaining_reg;
            meta = meta_kind_reg;
            tacc = tempo_accum_reg;
            rs   = running_status_reg;
        end
        bc_inc    = (bc == '1) ? bc : bc + 32'd1;
        vlq_shift = {vlq[24:0], b[6:0]};
        len_shift = {cl[23:0], b};
        skip_dec  = (skip == '0) ? skip : skip - 32'd1;
        n_status  = data_bytes_for(b);
        n_run     = data_bytes_for(rs);
        end_hit   = (bc_inc >= cl);
        is_tempo  = (meta == META_TEMPO) && (vlq_shift == TEMPO_LEN);
    end

    always_comb
    begin
        emit = 1'b0;
        result.tempo_period = default_tempo;
        result.tempo_found  = 1'b0;
        unique case (ph)
            PH_HEADER:
                emit = (hc == HDR_LAST) && (len_shift == '0);
            PH_STATUS:
            begin
                if (b == ST_META || b == ST_SYSEX || b == ST_SYSEX_CT)
                    emit = 1'b0;
                else if (b >= ST_SYSTEM)
                    emit = end_hit;
                else if (b >= ST_CHANNEL)
                    emit = (n_status == 2'd0) && end_hit;
                else
                    emit = (n_run <= 2'd1) && end_hit;
            end
            PH_META_LEN:
                emit = !b[7] && !is_tempo && (vlq_shift == '0) && end_hit;
            PH_SYSEX_LEN:
                emit = !b[7] && (vlq_shift == '0) && end_hit;
            PH_SKIP:
                emit = (skip_dec == '0) && end_hit;
            PH_TEMPO:
            begin
                emit = (skip_dec == '0);
                result.tempo_period = {tacc[15:0], b};
                result.tempo_found  = 1'b1;
            end
            default:
                emit = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next          = ph;
        header_count_next   = hc;
        chunk_length_next   = cl;
        bytes_consumed_next = bc;
        vlq_value_next      = vlq;
        skip_remaining_next = skip;
        meta_kind_next      = meta;
        tempo_accum_next    = tacc;
        running_status_next = rs;
        unique case (ph)
            PH_IDLE, PH_DONE:
                phase_next = ph;
            PH_HEADER:
            begin
                if (hc >= HDR_LEN_START)
                    chunk_length_next = len_shift;
                if (hc == HDR_LAST)
                begin
                    header_count_next   = '0;
                    bytes_consumed_next = '0;
                    phase_next          = PH_DELTA;
                end
                else
                    header_count_next = hc + 3'd1;
            end
            PH_DELTA:
            begin
                bytes_consumed_next = bc_inc;
                if (!b[7])
                    phase_next = PH_STATUS;
            end
            PH_STATUS:
            begin
                bytes_consumed_next = bc_inc;
                if (b == ST_META)
                begin
                    running_status_next = '0;
                    phase_next          = PH_META_TYPE;
                end
                else if (b == ST_SYSEX || b == ST_SYSEX_CT)
                begin
                    running_status_next = '0;
                    vlq_value_next      = '0;
                    phase_next          = PH_SYSEX_LEN;
                end
                else if (b >= ST_SYSTEM)
                begin
                    running_status_next = '0;
                    phase_next          = PH_DELTA;
                end
                else if (b >= ST_CHANNEL)
                begin
                    running_status_next = b;
                    if (n_status == 2'd0)
                        phase_next = PH_DELTA;
                    else
                    begin
                        skip_remaining_next = {30'd0, n_status};
                        phase_next          = PH_SKIP;
                    end
                end
                else if (n_run <= 2'd1)
                    phase_next = PH_DELTA;
                else
                begin
                    skip_remaining_next = {30'd0, n_run - 2'd1};
                    phase_next          = PH_SKIP;
                end
            end
            PH_META_TYPE:
            begin
                bytes_consumed_next = bc_inc;
                meta_kind_next      = b;
                vlq_value_next      = '0;
                phase_next          = PH_META_LEN;
            end
            PH_META_LEN:
            begin
                bytes_consumed_next = bc_inc;
                vlq_value_next      = vlq_shift;
                if (!b[7])
                begin
                    if (is_tempo)
                    begin
                        skip_remaining_next = TEMPO_LEN;
                        tempo_accum_next    = '0;
                        phase_next          = PH_TEMPO;
                    end
                    else if (vlq_shift == '0)
                        phase_next = PH_DELTA;
                    else
                    begin
                        skip_remaining_next = vlq_shift;
                        phase_next          = PH_SKIP;
                    end
                end
            end
            PH_SYSEX_LEN:
            begin
                bytes_consumed_next = bc_inc;
                vlq_value_next      = vlq_shift;
                if (!b[7])
                begin
                    if (vlq_shift == '0)
                        phase_next = PH_DELTA;
                    else
                    begin
                        skip_remaining_next = vlq_shift;
                        phase_next          = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                bytes_consumed_next = bc_inc;
                skip_remaining_next = skip_dec;
                if (skip_dec == '0)
                    phase_next = PH_DELTA;
            end
            PH_TEMPO:
            begin
                bytes_consumed_next = bc_inc;
                skip_remaining_next = skip_dec;
                tempo_accum_next    = {tacc[15:0], b};
            end
            default:
                phase_next = PH_IDLE;
        endcase
        if (emit)
            phase_next = PH_DONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            header_count_reg   <= '0;
            chunk_length_reg   <= '0;
            bytes_consumed_reg <= '0;
            vlq_value_reg      <= '0;
            skip_remaining_reg <= '0;
            meta_kind_reg      <= '0;
            tempo_accum_reg    <= '0;
            running_status_reg <= '0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            header_count_reg   <= header_count_next;
            chunk_length_reg   <= chunk_length_next;
            bytes_consumed_reg <= bytes_consumed_next;
            vlq_value_reg      <= vlq_value_next;
            skip_remaining_reg <= skip_remaining_next;
            meta_kind_reg      <= meta_kind_next;
            tempo_accum_reg    <= tempo_accum_next;
            running_status_reg <= running_status_next;
        end
    end

endmodule

`default_nettype wire

### hdl/midi_track_tempo_scanner.sv
// Tempo scanner for one MIDI track chunk.
// Request channel (req_valid, req_stall, req_data): one raw chunk byte per
// request, chunk_start set on the first header byte. Response channel
// (rsp_valid, rsp_stall, rsp_data): at most one response per chunk, the first
// set-tempo value with tempo_found set, or default_tempo with tempo_found clear
// when the chunk length runs out at an event boundary.
// Configuration: cfg_write loads cfg_data into default_tempo (reset 500000);
// write only while no request is in flight.
// Throughput: one byte per cycle unless a stalled response holds the byte
// that completes the next one; set by the single input register feeding the
// parse logic. Responses are registered in the output register (rsp_valid).
// Reset: the scan goes idle and ignores bytes until the next chunk_start;
// no response is pending.
// Stall: a pending response holds in the output register; the input register
// keeps taking bytes that produce no response, and holds the one that does
// until the response slot frees up.
`default_nettype none

module midi_track_tempo_scanner
    import mtts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire req_item_t   req_data,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output rsp_item_t        rsp_data,
    input  wire logic        cfg_write,
    input  wire logic [23:0] cfg_data
);

    logic        in_valid_reg;
    req_item_t   in_item_reg;
    logic        out_valid_reg;
    rsp_item_t   out_item_reg;
    logic [23:0] default_tempo_reg;

    logic        advance;
    logic        accept;
    logic        emit;
    rsp_item_t   result;

    mtts_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .item          (in_item_reg),
        .default_tempo (default_tempo_reg),
        .emit          (emit),
        .result        (result)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || !rsp_stall || !emit);
    assign req_stall = in_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= req_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && emit)
            out_valid_reg <= 1'b1;
        else if (!rsp_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            out_item_reg <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            default_tempo_reg <= DEFAULT_TEMPO_RESET;
        else if (cfg_write)
            default_tempo_reg <= cfg_data;
    end

    a_emit_loads_response: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> rsp_valid)
        else $error("response lost after emit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |-> !(out_valid_reg && rsp_stall))
        else $error("stalled response overwritten");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> in_valid_reg && emit && out_valid_reg)
        else $error("stall without held request");

endmodule

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mtts_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_SHOWN = 10;
    localparam int PHASE_ITEMS = 215;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_item_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_item_t rsp_data;
    logic cfg_write = 1'b0;
    logic [23:0] cfg_data = '0;

    req_item_t pend_q[$];
    req_item_t chunk_q[$];
    logic [7:0] body_q[$];
    rsp_item_t tempo_q[$];

    int gap_pct = 0;
    int stall_pct = 0;
    int gap_left = 0;
    int stall_left = 0;
    int bad_cnt = 0;
    int cyc = 0;
    int n_items = 0;

    phase_t scan_ph;
    logic [2:0] hdr_idx;
    logic [31:0] trk_len;
    logic [31:0] body_cnt;
    logic [31:0] vlq_acc;
    logic [31:0] skip_left;
    logic [7:0] meta_type;
    logic [7:0] run_stat;
    logic [23:0] tempo_acc;
    logic [23:0] dflt_tempo;
    logic [7:0] gen_run;

    midi_track_tempo_scanner u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int chan_len(input logic [7:0] st);
        case (st[7:4])
            HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CTRL, HI_PITCH: return 2;
            HI_PROGRAM, HI_CHAN_AT: return 1;
            default: return 0;
        endcase
    endfunction

    task automatic scan_clear();
        scan_ph = PH_IDLE;
        hdr_idx = '0;
        trk_len = '0;
        body_cnt = '0;
        vlq_acc = '0;
        skip_left = '0;
        meta_type = '0;
        tempo_acc = '0;
        run_stat = '0;
    endtask

    task automatic post_tempo(input logic [23:0] t, input logic found);
        rsp_item_t r;
        r.tempo_period = t;
        r.tempo_found = found;
        tempo_q.push_back(r);
        scan_ph = PH_DONE;
    endtask

    task automatic close_event();
        scan_ph = PH_DELTA;
        if (body_cnt >= trk_len)
            post_tempo(dflt_tempo, 1'b0);
    endtask

    task automatic start_skip(input logic [31:0] n);
        if (n == 0)
            close_event();
        else
        begin
            skip_left = n;
            scan_ph = PH_SKIP;
        end
    endtask

    task automatic scan_byte(input req_item_t r);
        logic [7:0] b;
        int n;
        b = r.data_byte;
        if (r.chunk_start)
        begin
            scan_clear();
            scan_ph = PH_HEADER;
        end
        if (scan_ph == PH_IDLE || scan_ph == PH_DONE)
            return;
        if (scan_ph == PH_HEADER)
        begin
            if (hdr_idx >= HDR_LEN_START)
                trk_len = {trk_len[23:0], b};
            if (hdr_idx >= HDR_LAST)
            begin
                hdr_idx = '0;
                body_cnt = '0;
                close_event();
            end
            else
                hdr_idx = hdr_idx + 3'd1;
            return;
        end
        if (body_cnt != '1)
            body_cnt = body_cnt + 32'd1;
        case (scan_ph)
            PH_DELTA:
                if (!b[7])
                    scan_ph = PH_STATUS;
            PH_STATUS:
            begin
                if (b == ST_META)
                begin
                    run_stat = '0;
                    scan_ph = PH_META_TYPE;
                end
                else if (b == ST_SYSEX || b == ST_SYSEX_CT)
                begin
                    run_stat = '0;
                    vlq_acc = '0;
                    scan_ph = PH_SYSEX_LEN;
                end
                else if (b >= ST_SYSTEM)
                begin
                    run_stat = '0;
                    close_event();
                end
                else if (b >= ST_CHANNEL)
                begin
                    run_stat = b;
                    start_skip(32'(chan_len(b)));
                end
                else
                begin
                    n = chan_len(run_stat);
                    if (n <= 1)
                        close_event();
                    else
                        start_skip(32'(n - 1));
                end
            end
            PH_META_TYPE:
            begin
                meta_type = b;
                vlq_acc = '0;
                scan_ph = PH_META_LEN;
            end
            PH_META_LEN, PH_SYSEX_LEN:
            begin
                vlq_acc = {vlq_acc[24:0], b[6:0]};
                if (!b[7])
                begin
                    if (scan_ph == PH_META_LEN && meta_type == META_TEMPO &&
                        vlq_acc == TEMPO_LEN)
                    begin
                        skip_left = TEMPO_LEN;
                        tempo_acc = '0;
                        scan_ph = PH_TEMPO;
                    end
                    else
                        start_skip(vlq_acc);
                end
            end
            PH_SKIP:
            begin
                if (skip_left != 0)
                    skip_left = skip_left - 32'd1;
                if (skip_left == 0)
                    close_event();
            end
            PH_TEMPO:
            begin
                tempo_acc = {tempo_acc[15:0], b};
                if (skip_left != 0)
                    skip_left = skip_left - 32'd1;
                if (skip_left == 0)
                    post_tempo(tempo_acc, 1'b1);
            end
            default:
                scan_ph = PH_IDLE;
        endcase
    endtask

    task automatic stage(input logic [7:0] b, input logic st);
        req_item_t r;
        r.data_byte = b;
        r.chunk_start = st;
        chunk_q.push_back(r);
    endtask

    task automatic flush(input int cut);
        int k;
        for (k = 0; k < cut && k < chunk_q.size(); k++)
            pend_q.push_back(chunk_q[k]);
        n_items += k;
        chunk_q.delete();
    endtask

    task automatic stage_chunk(input logic [31:0] len, input bit real_tag);
        logic [31:0] tag;
        int k;
        tag = real_tag ? 32'h4D54726B : $urandom;
        for (k = 3; k >= 0; k--)
            stage(tag[8*k +: 8], k == 3);
        for (k = 3; k >= 0; k--)
            stage(len[8*k +: 8], 1'b0);
        foreach (body_q[i])
            stage(body_q[i], 1'b0);
        body_q.delete();
    endtask

    task automatic add_random(input int n);
        repeat (n) body_q.push_back(8'($urandom));
    endtask

    // junk puts a high group in front that shifts out of the 32-bit value
    task automatic add_vlq(input logic [31:0] v, input bit junk);
        logic [6:0] grp[5];
        int top;
        int pad;
        int k;
        top = 0;
        for (k = 0; k < 5; k++)
        begin
            grp[k] = 7'(v >> (7 * k));
            if (grp[k] != 0)
                top = k;
        end
        pad = junk ? 4 : ($urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : 0);
        if (junk)
            body_q.push_back({1'b1, 7'($urandom)});
        repeat (pad) body_q.push_back(8'h80);
        for (k = top; k >= 0; k--)
            body_q.push_back({k != 0, grp[k]});
    endtask

    task automatic add_event(input bit allow_tempo);
        int pick;
        int len;
        logic [7:0] st;
        logic [7:0] mt;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(1, 5) : $urandom_range(0, 1))
            body_q.push_back({1'b1, 7'($urandom)});
        body_q.push_back({1'b0, 7'($urandom)});
        pick = $urandom_range(0, 99);
        if (pick >= 80 && !allow_tempo)
            pick = $urandom_range(0, 79);
        if (pick < 30)
        begin
            st = {4'($urandom_range(8, 14)), 4'($urandom)};
            gen_run = st;
            body_q.push_back(st);
            add_random(chan_len(st));
        end
        else if (pick < 45)
        begin
            body_q.push_back({1'b0, 7'($urandom)});
            if (chan_len(gen_run) == 2)
                add_random(1);
        end
        else if (pick >= 68 && pick < 73)
        begin
            st = 8'($urandom_range(32'hF1, 32'hFE));
            if (st == ST_SYSEX_CT)
                st = st + 8'd1;
            gen_run = '0;
            body_q.push_back(st);
        end
        else
        begin
            gen_run = '0;
            len = $urandom_range(0, 6);
            mt = 8'($urandom);
            if (pick < 60 && mt == META_TEMPO && len == 3)
                len = 4;
            else if (pick >= 80)
            begin
                mt = META_TEMPO;
                len = 3;
            end
            else if (pick >= 73)
            begin
                mt = META_TEMPO;
                if (len == 3)
                    len = 6;
            end
            if (pick >= 60 && pick < 68)
                body_q.push_back($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_CT);
            else
            begin
                body_q.push_back(ST_META);
                body_q.push_back(mt);
            end
            add_vlq(32'(len), $urandom_range(0, 19) == 0);
            add_random(len);
        end
    endtask

    task automatic add_chunk();
        logic [31:0] len;
        req_item_t r;
        bit allow_tempo;
        gen_run = '0;
        allow_tempo = $urandom_range(0, 1);
        repeat ($urandom_range(0, 6)) add_event(allow_tempo);
        case ($urandom_range(0, 11))
            0: len = $urandom;
            1: len = $urandom_range(0, body_q.size());
            2: len = body_q.size() + $urandom_range(1, 3);
            3: len = '1;
            default: len = body_q.size();
        endcase
        stage_chunk(len, $urandom_range(0, 7) != 0);
        // cut short now and then so the next chunk start lands mid scan
        flush($urandom_range(0, 9) == 0 ? $urandom_range(1, chunk_q.size()) : chunk_q.size());
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
            begin
                r.data_byte = 8'($urandom);
                r.chunk_start = $urandom_range(0, 7) == 0;
                pend_q.push_back(r);
            end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pend_q.size() != 0 || req_valid || tempo_q.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data <= '0;
            gap_left = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                scan_byte(req_data);
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pend_q.size() != 0 && gap_pct != 0 &&
                         $urandom_range(0, 99) < gap_pct)
                begin
                    gap_left = $urandom_range(0, 4);
                    req_valid <= 1'b0;
                end
                else if (pend_q.size() != 0)
                begin
                    req_valid <= 1'b1;
                    req_data <= pend_q.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : mon
        rsp_item_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (tempo_q.size() == 0)
                begin
                    bad_cnt++;
                    if (bad_cnt <= MAX_SHOWN)
                        $display("unexpected response: tempo_period %0d tempo_found %0b",
                                 rsp_data.tempo_period, rsp_data.tempo_found);
                end
                else
                begin
                    want = tempo_q.pop_front();
                    if (rsp_data.tempo_period !== want.tempo_period ||
                        rsp_data.tempo_found !== want.tempo_found)
                    begin
                        bad_cnt++;
                        if (bad_cnt <= MAX_SHOWN)
                            $display({"response mismatch: expected tempo_period %0d ",
                                      "tempo_found %0b, got tempo_period %0d tempo_found %0b"},
                                     want.tempo_period, want.tempo_found,
                                     rsp_data.tempo_period, rsp_data.tempo_found);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 4);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cyc++;
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin : main
        logic [23:0] cfg_vals[6];
        int gap_sel[6];
        int stall_sel[6];
        int target;
        int p;
        cfg_vals[0] = 24'd0;
        cfg_vals[1] = 24'hFFFFFF;
        cfg_vals[2] = 24'($urandom);
        cfg_vals[3] = 24'd1;
        cfg_vals[4] = 24'($urandom);
        cfg_vals[5] = DEFAULT_TEMPO_RESET;
        gap_sel = '{30, 0, 50, 15, 40, 0};
        stall_sel = '{40, 20, 0, 50, 25, 0};
        scan_clear();
        dflt_tempo = DEFAULT_TEMPO_RESET;
        gen_run = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        gap_pct = 20;
        stall_pct = 20;
        stage(8'hA5, 1'b0);
        stage_chunk(32'd0, 1'b1);
        body_q = '{8'h00, ST_META, META_TEMPO, 8'h03, 8'hFF, 8'hFF, 8'hFF};
        stage_chunk(32'd7, 1'b1);
        flush(chunk_q.size());
        drain();

        target = n_items;
        for (p = 0; p < 6; p++)
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_data <= cfg_vals[p];
            dflt_tempo = cfg_vals[p];
            @(posedge clk);
            cfg_write <= 1'b0;
            gap_pct = gap_sel[p];
            stall_pct = stall_sel[p];
            target += PHASE_ITEMS;
            while (n_items < target)
                add_chunk();
            drain();
        end

        if (bad_cnt == 0 && tempo_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
